[rtl/c3cf_pkg.sv]
// Shared types and constants of the 3x3 clamp filter.
// Used by c3cf_line_buf, c3cf_kernel and conv3x3_clamp_filter; no dependencies.
package c3cf_pkg;

	localparam int MAX_WIDTH_DEF      = 1024;
	localparam int COEF_FRAC_BITS_DEF = 8;

	localparam int PIX_W   = 8;
	localparam int ROW_W   = 12;
	localparam int COL_W   = 10;
	localparam int WID_W   = 11;
	localparam int HGT_W   = 13;
	localparam int COEF_RW = 36;
	localparam int TAPS    = 9;
	localparam int PIX_MAX = 255;
	localparam int MAX_HEIGHT = 4096;
	// Running sum stays within +/- 9 * 255 * 8, so 16 signed bits hold it.
	localparam int SUM_W   = 16;

	localparam logic [WID_W-1:0]   WIDTH_RST  = WID_W'(320);
	localparam logic [HGT_W-1:0]   HEIGHT_RST = HGT_W'(240);
	localparam logic [COEF_RW-1:0] COEF_TOP_RST = '0;
	localparam logic [COEF_RW-1:0] COEF_MID_RST = COEF_RW'(36'h000100000);
	localparam logic [COEF_RW-1:0] COEF_BOT_RST = '0;

	typedef enum logic [2:0] {
		REG_IMAGE_WIDTH  = 3'd0,
		REG_IMAGE_HEIGHT = 3'd1,
		REG_COEF_TOP     = 3'd2,
		REG_COEF_MID     = 3'd3,
		REG_COEF_BOTTOM  = 3'd4
	} cfg_reg_t;

	// Position of the centre pixel of one result.
	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             last;
	} res_meta_t;

	// One window beat: nine pixels row-major, top-left first, plus position.
	typedef struct packed {
		logic [TAPS-1:0][PIX_W-1:0] pix;
		res_meta_t                  meta;
	} win_beat_t;

endpackage

[rtl/c3cf_line_buf.sv]
// Raster position counters, two line stores and the 3x3 pixel window.
// Depends on c3cf_pkg; feeds window beats to c3cf_kernel.
module c3cf_line_buf #(
	parameter int MAX_WIDTH = c3cf_pkg::MAX_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [c3cf_pkg::PIX_W-1:0]     pixel_in,
	input  logic [c3cf_pkg::WID_W-1:0]     image_width,
	input  logic [c3cf_pkg::HGT_W-1:0]     image_height,
	output logic                           win_valid,
	input  logic                           win_ready,
	output c3cf_pkg::win_beat_t            win
);

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WW = (CW + 1 > c3cf_pkg::WID_W) ? CW + 1 : c3cf_pkg::WID_W;
	localparam int HW = c3cf_pkg::HGT_W;
	localparam int PW = c3cf_pkg::PIX_W;

	logic [PW-1:0] older_mem [MAX_WIDTH];
	logic [PW-1:0] newer_mem [MAX_WIDTH];

	logic [CW-1:0]                col_q;
	logic [c3cf_pkg::ROW_W-1:0]   row_q;

	logic [WW-1:0] eff_w, wid_ext, col_ext, col_next;
	logic [HW-1:0] eff_h, row_ext, row_next;
	logic          accept, hit;

	logic                  valid_s1;
	logic [PW-1:0]         px_s1, older_rd_s1, newer_rd_s1;
	logic [CW-1:0]         ci_s1;
	logic                  hit_s1;
	c3cf_pkg::res_meta_t   meta_s1, meta_d;

	logic                  valid_s2;
	logic [PW-1:0]         win_q [3][3];
	c3cf_pkg::res_meta_t   meta_s2;
	logic                  s2_free, s1_move;

	// Clamp the width to 3..MAX_WIDTH and the height to 3..MAX_HEIGHT.
	always_comb begin
		wid_ext = WW'(image_width);
		if (wid_ext < WW'(3)) begin
			eff_w = WW'(3);
		end else if (wid_ext > WW'(MAX_WIDTH)) begin
			eff_w = WW'(MAX_WIDTH);
		end else begin
			eff_w = wid_ext;
		end
		if (image_height < HW'(3)) begin
			eff_h = HW'(3);
		end else if (image_height > HW'(c3cf_pkg::MAX_HEIGHT)) begin
			eff_h = HW'(c3cf_pkg::MAX_HEIGHT);
		end else begin
			eff_h = image_height;
		end
	end

	assign col_ext  = WW'(col_q);
	assign row_ext  = HW'(row_q);
	assign col_next = col_ext + WW'(1);
	assign row_next = row_ext + HW'(1);

	assign hit = (row_q >= c3cf_pkg::ROW_W'(2)) && (col_ext >= WW'(2))
		&& (row_ext < eff_h) && (col_ext < eff_w);

	always_comb begin
		meta_d.row  = row_q - c3cf_pkg::ROW_W'(1);
		meta_d.col  = c3cf_pkg::COL_W'(col_ext - WW'(1));
		meta_d.last = (row_next == eff_h) && (col_next == eff_w);
	end

	assign s2_free  = !valid_s2 || win_ready;
	assign s1_move  = valid_s1 && s2_free;
	assign in_ready = !valid_s1 || s2_free;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_next >= eff_w) begin
				col_q <= '0;
				row_q <= (row_next >= eff_h) ? '0 : c3cf_pkg::ROW_W'(row_next);
			end else begin
				col_q <= CW'(col_next);
			end
		end
	end

	// Line stores: read on accept, write back when the beat leaves stage 1.
	always_ff @(posedge clk) begin
		if (accept) begin
			older_rd_s1 <= older_mem[col_q];
			newer_rd_s1 <= newer_mem[col_q];
		end
		if (s1_move) begin
			older_mem[ci_s1] <= newer_rd_s1;
			newer_mem[ci_s1] <= px_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1   <= pixel_in;
			ci_s1   <= col_q;
			hit_s1  <= hit;
			meta_s1 <= meta_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[i][j] <= '0;
				end
			end
		end else if (s2_free) begin
			valid_s2 <= s1_move && hit_s1;
			if (s1_move) begin
				for (int i = 0; i < 3; i++) begin
					win_q[i][0] <= win_q[i][1];
					win_q[i][1] <= win_q[i][2];
				end
				win_q[0][2] <= older_rd_s1;
				win_q[1][2] <= newer_rd_s1;
				win_q[2][2] <= px_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			meta_s2 <= meta_s1;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				win.pix[i*3+j] = win_q[i][j];
			end
		end
		win.meta = meta_s2;
	end

	assign win_valid = valid_s2;

	a_col_moves: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> col_q != $past(col_q))
		else $error("column counter did not advance on an accepted pixel");

	a_win_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s2) |-> $past(valid_s1))
		else $error("window beat appeared without a pixel in stage 1");

endmodule

[rtl/c3cf_kernel.sv]
// Nine-tap multiply, truncating row-major accumulation and byte clamp.
// Depends on c3cf_pkg; takes window beats from c3cf_line_buf.
module c3cf_kernel #(
	parameter int COEF_FRAC_BITS = c3cf_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       win_valid,
	output logic                                       win_ready,
	input  c3cf_pkg::win_beat_t                        win,
	input  logic [2:0][c3cf_pkg::COEF_RW-1:0]          coef_rows,
	output logic                                       out_valid,
	input  logic                                       out_ready,
	output logic [c3cf_pkg::PIX_W-1:0]                 pixel_out,
	output c3cf_pkg::res_meta_t                        meta_out
);

	localparam int F    = COEF_FRAC_BITS;
	localparam int CWID = 4 + F;
	localparam int PW   = 9 + CWID;
	localparam int SW   = c3cf_pkg::SUM_W;
	localparam int TW   = SW + F + 1;
	localparam int RW   = (3 * CWID > c3cf_pkg::COEF_RW) ? 3 * CWID : c3cf_pkg::COEF_RW;

	logic signed [PW-1:0] prod_d  [9];
	logic signed [PW-1:0] prod_s3 [9];
	logic signed [PW-1:0] prod_s4 [6];
	logic signed [PW-1:0] prod_s5 [3];
	logic signed [SW-1:0] sum_s4, sum_s5, sum_fin;
	logic [c3cf_pkg::PIX_W-1:0] pix_s6;
	c3cf_pkg::res_meta_t  meta_s3, meta_s4, meta_s5, meta_s6;
	logic v3, v4, v5, v6, rdy3, rdy4, rdy5, rdy6;

	// One tap: scale the sum up, add the product, divide back toward zero.
	function automatic logic signed [SW-1:0] tap(input logic signed [SW-1:0] s,
		input logic signed [PW-1:0] p);
		logic signed [TW-1:0] t;
		logic signed [TW-1:0] q;
		t = (TW'(s) <<< F) + TW'(p);
		q = t >>> F;
		if (t[TW-1] && (t[F-1:0] != '0)) begin
			q = q + TW'(1);
		end
		return SW'(q);
	endfunction

	for (genvar k = 0; k < 9; k++) begin : g_tap
		localparam int TR = k / 3;
		localparam int TC = k % 3;
		logic [RW-1:0]          row_ext;
		logic signed [CWID-1:0] coef;
		assign row_ext   = RW'(coef_rows[TR]);
		assign coef      = row_ext[TC*CWID +: CWID];
		assign prod_d[k] = $signed({1'b0, win.pix[k]}) * coef;
	end

	assign rdy6      = !v6 || out_ready;
	assign rdy5      = !v5 || rdy6;
	assign rdy4      = !v4 || rdy5;
	assign rdy3      = !v3 || rdy4;
	assign win_ready = rdy3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v3 <= 1'b0;
			v4 <= 1'b0;
			v5 <= 1'b0;
			v6 <= 1'b0;
		end else begin
			if (rdy3) begin
				v3 <= win_valid;
			end
			if (rdy4) begin
				v4 <= v3;
			end
			if (rdy5) begin
				v5 <= v4;
			end
			if (rdy6) begin
				v6 <= v5;
			end
		end
	end

	always_comb begin
		sum_fin = tap(tap(tap(sum_s5, prod_s5[0]), prod_s5[1]), prod_s5[2]);
	end

	always_ff @(posedge clk) begin
		if (rdy3 && win_valid) begin
			prod_s3 <= prod_d;
			meta_s3 <= win.meta;
		end
		if (rdy4 && v3) begin
			sum_s4  <= tap(tap(tap(SW'(0), prod_s3[0]), prod_s3[1]), prod_s3[2]);
			for (int i = 0; i < 6; i++) begin
				prod_s4[i] <= prod_s3[i+3];
			end
			meta_s4 <= meta_s3;
		end
		if (rdy5 && v4) begin
			sum_s5  <= tap(tap(tap(sum_s4, prod_s4[0]), prod_s4[1]), prod_s4[2]);
			for (int i = 0; i < 3; i++) begin
				prod_s5[i] <= prod_s4[i+3];
			end
			meta_s5 <= meta_s4;
		end
		if (rdy6 && v5) begin
			if (sum_fin < 0) begin
				pix_s6 <= '0;
			end else if (sum_fin > SW'(c3cf_pkg::PIX_MAX)) begin
				pix_s6 <= c3cf_pkg::PIX_W'(c3cf_pkg::PIX_MAX);
			end else begin
				pix_s6 <= sum_fin[c3cf_pkg::PIX_W-1:0];
			end
			meta_s6 <= meta_s5;
		end
	end

	assign out_valid = v6;
	assign pixel_out = pix_s6;
	assign meta_out  = meta_s6;

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(v6) |-> $past(v5))
		else $error("result appeared without a beat in the last sum stage");

endmodule

[rtl/conv3x3_clamp_filter.sv]
// Top level of the 3x3 convolution filter with byte clamp.
// Depends on c3cf_pkg, c3cf_line_buf and c3cf_kernel.
//
//  channel | handshake              | payload
//  --------+------------------------+------------------------------------------
//  input   | in_valid / in_ready    | pixel_in
//  output  | out_valid / out_ready  | pixel_out, out_row, out_col, frame_last
//  config  | cfg_valid / cfg_ready  | cfg_index, cfg_data (always ready)
//
// One pixel per clock, sustained while out_ready stays high; each pixel passes
// stage 1 line store read, window, products and three sum stages of three taps.
// The rate is set by the single read and single write per cycle on each line store.
// Reset clears counters, window and valid bits; line stores are not cleared.
// A stall on out_ready backs up stage by stage; empty stages keep taking pixels.
// Only interior centre pixels give a result; border pixels are dropped.
module conv3x3_clamp_filter #(
	parameter int MAX_WIDTH      = c3cf_pkg::MAX_WIDTH_DEF,
	parameter int COEF_FRAC_BITS = c3cf_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [c3cf_pkg::PIX_W-1:0]         pixel_in,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [c3cf_pkg::PIX_W-1:0]         pixel_out,
	output logic [c3cf_pkg::ROW_W-1:0]         out_row,
	output logic [c3cf_pkg::COL_W-1:0]         out_col,
	output logic                               frame_last,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [2:0]                         cfg_index,
	input  logic [c3cf_pkg::COEF_RW-1:0]       cfg_data
);

	logic [c3cf_pkg::WID_W-1:0]          width_q;
	logic [c3cf_pkg::HGT_W-1:0]          height_q;
	logic [2:0][c3cf_pkg::COEF_RW-1:0]   coef_q;

	logic                   win_valid, win_ready;
	c3cf_pkg::win_beat_t    win;
	c3cf_pkg::res_meta_t    meta_out;

	// Configuration writes are registered on the accepting edge; never hold off the port.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= c3cf_pkg::WIDTH_RST;
			height_q  <= c3cf_pkg::HEIGHT_RST;
			coef_q[0] <= c3cf_pkg::COEF_TOP_RST;
			coef_q[1] <= c3cf_pkg::COEF_MID_RST;
			coef_q[2] <= c3cf_pkg::COEF_BOT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				c3cf_pkg::REG_IMAGE_WIDTH:  width_q   <= cfg_data[c3cf_pkg::WID_W-1:0];
				c3cf_pkg::REG_IMAGE_HEIGHT: height_q  <= cfg_data[c3cf_pkg::HGT_W-1:0];
				c3cf_pkg::REG_COEF_TOP:     coef_q[0] <= cfg_data;
				c3cf_pkg::REG_COEF_MID:     coef_q[1] <= cfg_data;
				c3cf_pkg::REG_COEF_BOTTOM:  coef_q[2] <= cfg_data;
				default: ;  // drop writes beyond the register list
			endcase
		end
	end

	// Position tracking, line stores and window.
	c3cf_line_buf #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_line_buf (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.pixel_in     (pixel_in),
		.image_width  (width_q),
		.image_height (height_q),
		.win_valid    (win_valid),
		.win_ready    (win_ready),
		.win          (win)
	);

	// Multiply, accumulate with truncation after every tap, clamp.
	c3cf_kernel #(
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_kernel (
		.clk       (clk),
		.arst_n    (arst_n),
		.win_valid (win_valid),
		.win_ready (win_ready),
		.win       (win),
		.coef_rows (coef_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pixel_out (pixel_out),
		.meta_out  (meta_out)
	);

	assign out_row    = meta_out.row;
	assign out_col    = meta_out.col;
	assign frame_last = meta_out.last;

	a_row_interior: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_row != '0)
		else $error("result beat carries a border row");

endmodule

[verif/tb_conv3x3_clamp_filter.sv]
// Self-checking testbench for the 3x3 convolution filter with byte clamp.
// Depends on c3cf_pkg and the conv3x3_clamp_filter RTL; keeps its own filter model.
`timescale 1ns / 1ps

module tb_conv3x3_clamp_filter;

	// Geometry floor, coefficient layout and fixed-point scale of the filter.
	localparam int          MIN_DIM      = 3;
	localparam int          COEF_W       = 4 + c3cf_pkg::COEF_FRAC_BITS_DEF;
	localparam longint      COEF_SCALE   = longint'(1) << c3cf_pkg::COEF_FRAC_BITS_DEF;
	// Register indexes past the last register; writes there must be dropped.
	localparam logic [2:0]  CFG_IDX_SPARE_LO = 3'(c3cf_pkg::REG_COEF_BOTTOM) + 3'd1;
	localparam logic [2:0]  CFG_IDX_SPARE_HI = 3'b111;
	// Pipeline is six deep; leave margin before touching registers.
	localparam int          SETTLE_CYCLES = 16;
	localparam int          STALL_MAX     = 12;
	localparam int          WATCHDOG_LIMIT = 2000;
	localparam int          RANDOM_ITEMS  = 360;
	localparam int          TALL_ROWS     = 8;

	typedef enum int {IDLE_NONE, IDLE_RANDOM, IDLE_SPARSE} idle_mode_t;

	// One filtered pixel as it should leave the block.
	typedef struct {
		logic [c3cf_pkg::PIX_W-1:0] pix;
		logic [c3cf_pkg::ROW_W-1:0] row;
		logic [c3cf_pkg::COL_W-1:0] col;
		logic                       last;
	} filt_result_t;

	logic                         clk;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_ready;
	logic [c3cf_pkg::PIX_W-1:0]   pixel_in;
	logic                         out_valid;
	logic                         out_ready;
	logic [c3cf_pkg::PIX_W-1:0]   pixel_out;
	logic [c3cf_pkg::ROW_W-1:0]   out_row;
	logic [c3cf_pkg::COL_W-1:0]   out_col;
	logic                         frame_last;
	logic                         cfg_valid;
	logic                         cfg_ready;
	logic [2:0]                   cfg_index;
	logic [c3cf_pkg::COEF_RW-1:0] cfg_data;

	conv3x3_clamp_filter u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.pixel_in   (pixel_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pixel_out  (pixel_out),
		.out_row    (out_row),
		.out_col    (out_col),
		.frame_last (frame_last),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// ------------------------------------------------------------------
	// Filter model state: its own copy of registers, line stores, window
	// and raster position. The line stores start at zero here, but the
	// stimulus never lets an unwritten entry reach a result.
	// ------------------------------------------------------------------
	logic [c3cf_pkg::WID_W-1:0]   img_width_reg;
	logic [c3cf_pkg::HGT_W-1:0]   img_height_reg;
	logic [c3cf_pkg::COEF_RW-1:0] coef_rows [3];
	logic [c3cf_pkg::PIX_W-1:0]   line_older [c3cf_pkg::MAX_WIDTH_DEF];
	logic [c3cf_pkg::PIX_W-1:0]   line_newer [c3cf_pkg::MAX_WIDTH_DEF];
	logic [c3cf_pkg::PIX_W-1:0]   win_px [3][3];   // [row][col], col 2 newest
	int unsigned                  next_col;
	int unsigned                  next_row;

	filt_result_t       expected_results [$];

	idle_mode_t         in_idle;
	idle_mode_t         out_idle;
	int                 mismatches;
	int unsigned        pixels_sent;
	int unsigned        results_seen;
	int unsigned        cfg_writes;
	int unsigned        frames_done;
	int unsigned        quiet_cycles;

	// Clock: 10 ns period.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ------------------------------------------------------------------
	// Model helpers
	// ------------------------------------------------------------------
	function automatic int unsigned used_width();
		if (img_width_reg < MIN_DIM) return MIN_DIM;
		if (img_width_reg > c3cf_pkg::MAX_WIDTH_DEF) return c3cf_pkg::MAX_WIDTH_DEF;
		return img_width_reg;
	endfunction

	function automatic int unsigned used_height();
		if (img_height_reg < MIN_DIM) return MIN_DIM;
		if (img_height_reg > c3cf_pkg::MAX_HEIGHT) return c3cf_pkg::MAX_HEIGHT;
		return img_height_reg;
	endfunction

	// Pull one signed Q4.8 coefficient out of a packed row; left tap is lowest.
	function automatic longint tap_coef(input logic [c3cf_pkg::COEF_RW-1:0] row_bits,
			input int unsigned idx);
		logic signed [COEF_W-1:0] v;
		v = row_bits[idx*COEF_W +: COEF_W];
		return longint'(v);
	endfunction

	// Advance the model by one accepted pixel; queue a result for interior centres.
	task automatic filter_pixel(input logic [c3cf_pkg::PIX_W-1:0] px);
		int unsigned  w, h, c, r, ci, tr, tc;
		longint       acc;
		filt_result_t res;
		w  = used_width();
		h  = used_height();
		c  = next_col;
		r  = next_row;
		ci = (c < c3cf_pkg::MAX_WIDTH_DEF) ? c : 0;
		// Shift the window left and load the new column from the line stores.
		for (int i = 0; i < 3; i++) begin
			win_px[i][0] = win_px[i][1];
			win_px[i][1] = win_px[i][2];
		end
		win_px[0][2]  = line_older[ci];
		win_px[1][2]  = line_newer[ci];
		win_px[2][2]  = px;
		line_older[ci] = line_newer[ci];
		line_newer[ci] = px;
		if (r >= 2 && c >= 2 && r < h && c < w) begin
			// Row-major taps, truncating toward zero after every tap.
			acc = 0;
			for (int k = 0; k < c3cf_pkg::TAPS; k++) begin
				tr  = k / 3;
				tc  = k % 3;
				acc = (acc * COEF_SCALE
					+ longint'(win_px[tr][tc]) * tap_coef(coef_rows[tr], tc)) / COEF_SCALE;
			end
			if (acc < 0) acc = 0;
			if (acc > c3cf_pkg::PIX_MAX) acc = c3cf_pkg::PIX_MAX;
			res.pix  = c3cf_pkg::PIX_W'(acc);
			res.row  = c3cf_pkg::ROW_W'(r - 1);
			res.col  = c3cf_pkg::COL_W'(c - 1);
			res.last = (r + 1 == h) && (c + 1 == w);
			expected_results.push_back(res);
		end
		// A counter at or past a freshly lowered limit wraps on this advance.
		if (c + 1 >= w) begin
			next_col = 0;
			next_row = (r + 1 >= h) ? 0 : r + 1;
		end else begin
			next_col = c + 1;
		end
	endtask

	// ------------------------------------------------------------------
	// Random draws
	// ------------------------------------------------------------------
	function automatic int draw_gap(input idle_mode_t mode);
		case (mode)
			IDLE_RANDOM: return $urandom_range(0, STALL_MAX);
			IDLE_SPARSE: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, STALL_MAX) : 0;
			default:     return 0;
		endcase
	endfunction

	function automatic idle_mode_t pick_idle();
		case ($urandom_range(0, 3))
			0:       return IDLE_NONE;
			1:       return IDLE_SPARSE;
			default: return IDLE_RANDOM;
		endcase
	endfunction

	// Extremes-heavy mode puts many pixels at 0 and 255.
	function automatic logic [c3cf_pkg::PIX_W-1:0] draw_pixel(input bit extremes);
		if (extremes) begin
			case ($urandom_range(0, 2))
				0:       return '0;
				1:       return '1;
				default: return c3cf_pkg::PIX_W'($urandom);
			endcase
		end
		return c3cf_pkg::PIX_W'($urandom);
	endfunction

	// Full-range rows mostly clamp; small rows draw each Q4.8 tap from -0.375 to +0.625.
	function automatic logic [c3cf_pkg::COEF_RW-1:0] draw_coef_row(input bit full_range);
		logic [c3cf_pkg::COEF_RW-1:0] row_bits;
		for (int i = 0; i < 3; i++) begin
			if (full_range)
				row_bits[i*COEF_W +: COEF_W] = COEF_W'($urandom);
			else
				row_bits[i*COEF_W +: COEF_W] = COEF_W'(int'($urandom_range(0, 256)) - 96);
		end
		return row_bits;
	endfunction

	function automatic logic [c3cf_pkg::COEF_RW-1:0] rand_word();
		return c3cf_pkg::COEF_RW'({$urandom, $urandom});
	endfunction

	// Mostly small widths, some below the floor; junk above the field now and then.
	function automatic logic [c3cf_pkg::COEF_RW-1:0] draw_width_data();
		logic [c3cf_pkg::COEF_RW-1:0] v;
		case ($urandom_range(0, 9))
			0:       v = c3cf_pkg::COEF_RW'($urandom_range(0, MIN_DIM - 1));
			1:       v = c3cf_pkg::COEF_RW'($urandom_range(17, 48));
			default: v = c3cf_pkg::COEF_RW'($urandom_range(MIN_DIM, 16));
		endcase
		if ($urandom_range(0, 3) == 0)
			v = v | (rand_word() & ~c3cf_pkg::COEF_RW'({c3cf_pkg::WID_W{1'b1}}));
		return v;
	endfunction

	function automatic logic [c3cf_pkg::COEF_RW-1:0] draw_height_data();
		logic [c3cf_pkg::COEF_RW-1:0] v;
		case ($urandom_range(0, 9))
			0:       v = c3cf_pkg::COEF_RW'($urandom_range(0, MIN_DIM - 1));
			1:       v = c3cf_pkg::COEF_RW'($urandom_range(9, 20));
			default: v = c3cf_pkg::COEF_RW'($urandom_range(MIN_DIM, 8));
		endcase
		if ($urandom_range(0, 3) == 0)
			v = v | (rand_word() & ~c3cf_pkg::COEF_RW'({c3cf_pkg::HGT_W{1'b1}}));
		return v;
	endfunction

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------
	// Send one pixel beat: idle for a drawn gap, then hold valid until accepted.
	task automatic send_pixel(input logic [c3cf_pkg::PIX_W-1:0] px);
		int gap;
		gap = draw_gap(in_idle);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		pixel_in <= px;
		do @(posedge clk); while (!in_ready);
		filter_pixel(px);
		pixels_sent++;
	endtask

	// Write one register beat; indexes past the list leave the model untouched.
	task automatic cfg_write(input logic [2:0] idx,
			input logic [c3cf_pkg::COEF_RW-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			c3cf_pkg::REG_IMAGE_WIDTH:  img_width_reg  = data[c3cf_pkg::WID_W-1:0];
			c3cf_pkg::REG_IMAGE_HEIGHT: img_height_reg = data[c3cf_pkg::HGT_W-1:0];
			c3cf_pkg::REG_COEF_TOP:     coef_rows[0]   = data;
			c3cf_pkg::REG_COEF_MID:     coef_rows[1]   = data;
			c3cf_pkg::REG_COEF_BOTTOM:  coef_rows[2]   = data;
			default: ;
		endcase
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Drop valid, wait out every queued result, then let border pixels flush.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Send pixels until the raster position is back at the top-left corner.
	task automatic finish_frame(input bit extremes);
		do send_pixel(draw_pixel(extremes)); while (next_col != 0 || next_row != 0);
		frames_done++;
	endtask

	task automatic write_kernel(input logic [c3cf_pkg::COEF_RW-1:0] top,
			input logic [c3cf_pkg::COEF_RW-1:0] mid,
			input logic [c3cf_pkg::COEF_RW-1:0] bot);
		cfg_write(c3cf_pkg::REG_COEF_TOP, top);
		cfg_write(c3cf_pkg::REG_COEF_MID, mid);
		cfg_write(c3cf_pkg::REG_COEF_BOTTOM, bot);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	// One full row at the reset width, then narrow rows finish the frame so the
	// identity kernel shows up in the results.
	task automatic test_reset_defaults();
		in_idle  = IDLE_SPARSE;
		out_idle = IDLE_SPARSE;
		repeat (used_width()) send_pixel(draw_pixel(1'b0));
		drain();
		cfg_write(c3cf_pkg::REG_IMAGE_WIDTH, c3cf_pkg::COEF_RW'(MIN_DIM));
		cfg_write(c3cf_pkg::REG_IMAGE_HEIGHT, c3cf_pkg::COEF_RW'(MIN_DIM));
		finish_frame(1'b0);
	endtask

	// Smallest frames with kernel and pixel extremes, sizes below the floor and
	// a write to an unused index.
	task automatic test_directed_extremes();
		in_idle  = IDLE_RANDOM;
		out_idle = IDLE_RANDOM;
		drain();
		// Width 0 and height 2 both act as 3. Largest positive taps saturate high.
		cfg_write(c3cf_pkg::REG_IMAGE_WIDTH, '0);
		cfg_write(c3cf_pkg::REG_IMAGE_HEIGHT, c3cf_pkg::COEF_RW'(2));
		write_kernel(36'h7FF7FF7FF, 36'h7FF7FF7FF, 36'h7FF7FF7FF);
		repeat (9) send_pixel('1);
		frames_done++;
		drain();
		// Most negative taps saturate low; the spare-index write must not land.
		write_kernel(36'h800800800, 36'h800800800, 36'h800800800);
		cfg_write(CFG_IDX_SPARE_HI, 36'h7FF7FF7FF);
		repeat (9) send_pixel('1);
		frames_done++;
		drain();
		// Fractional taps of both signs, where truncation toward zero shows.
		cfg_write(c3cf_pkg::REG_IMAGE_WIDTH, c3cf_pkg::COEF_RW'(4));
		write_kernel(36'h0400800C0, 36'hF80100F80, 36'h003FFF001);
		for (int i = 0; i < 12; i++) send_pixel((i % 3 == 0) ? '0 : (i % 3 == 1) ? '1 : 8'd77);
		frames_done++;
	endtask

	// Widest row: an oversized width clamps to the store depth. One full row,
	// then narrow rows finish the frame.
	task automatic test_width_extremes();
		in_idle  = IDLE_NONE;
		out_idle = IDLE_SPARSE;
		drain();
		cfg_write(c3cf_pkg::REG_IMAGE_WIDTH,
			rand_word() | c3cf_pkg::COEF_RW'({c3cf_pkg::WID_W{1'b1}}));
		cfg_write(c3cf_pkg::REG_IMAGE_HEIGHT, c3cf_pkg::COEF_RW'(MIN_DIM));
		write_kernel(draw_coef_row(1'b0), draw_coef_row(1'b0), draw_coef_row(1'b0));
		repeat (c3cf_pkg::MAX_WIDTH_DEF) send_pixel(draw_pixel(1'b1));
		drain();
		cfg_write(c3cf_pkg::REG_IMAGE_WIDTH, c3cf_pkg::COEF_RW'(MIN_DIM));
		finish_frame(1'b0);
	endtask

	// Oversized height on the narrowest rows, then a lower height while the row
	// counter sits past it.
	task automatic test_height_extremes();
		in_idle  = IDLE_NONE;
		out_idle = IDLE_NONE;
		drain();
		cfg_write(c3cf_pkg::REG_IMAGE_WIDTH, c3cf_pkg::COEF_RW'(MIN_DIM));
		cfg_write(c3cf_pkg::REG_IMAGE_HEIGHT, c3cf_pkg::COEF_RW'({c3cf_pkg::HGT_W{1'b1}}));
		write_kernel(draw_coef_row(1'b0), draw_coef_row(1'b0), draw_coef_row(1'b0));
		repeat (TALL_ROWS * MIN_DIM) send_pixel(draw_pixel(1'b0));
		drain();
		cfg_write(c3cf_pkg::REG_IMAGE_HEIGHT, c3cf_pkg::COEF_RW'(MIN_DIM));
		finish_frame(1'b0);
	endtask

	// Geometry changes while the raster position sits inside a frame.
	task automatic test_midframe_geometry();
		in_idle  = IDLE_RANDOM;
		out_idle = IDLE_RANDOM;
		drain();
		cfg_write(c3cf_pkg::REG_IMAGE_WIDTH, c3cf_pkg::COEF_RW'(10));
		cfg_write(c3cf_pkg::REG_IMAGE_HEIGHT, c3cf_pkg::COEF_RW'(8));
		repeat (37) send_pixel(draw_pixel(1'b0));
		drain();
		cfg_write(c3cf_pkg::REG_IMAGE_WIDTH, c3cf_pkg::COEF_RW'(5));
		repeat (12) send_pixel(draw_pixel(1'b0));
		drain();
		cfg_write(c3cf_pkg::REG_IMAGE_HEIGHT, c3cf_pkg::COEF_RW'(MIN_DIM));
		cfg_write(c3cf_pkg::REG_IMAGE_WIDTH, c3cf_pkg::COEF_RW'(14));
		finish_frame(1'b0);
	endtask

	// Many small frames with random geometry, kernels, pixels and idling; some
	// are cut short and resumed under new geometry.
	task automatic test_random_frames();
		int unsigned start_count;
		int unsigned cut;
		bit          extremes;
		start_count = pixels_sent;
		while (pixels_sent - start_count < RANDOM_ITEMS) begin
			drain();
			in_idle  = pick_idle();
			out_idle = pick_idle();
			extremes = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 3) != 0)
				cfg_write(c3cf_pkg::REG_IMAGE_WIDTH, draw_width_data());
			if ($urandom_range(0, 3) != 0)
				cfg_write(c3cf_pkg::REG_IMAGE_HEIGHT, draw_height_data());
			if ($urandom_range(0, 3) != 0)
				cfg_write(c3cf_pkg::REG_COEF_TOP, draw_coef_row($urandom_range(0, 3) == 0));
			if ($urandom_range(0, 3) != 0)
				cfg_write(c3cf_pkg::REG_COEF_MID, draw_coef_row($urandom_range(0, 3) == 0));
			if ($urandom_range(0, 3) != 0)
				cfg_write(c3cf_pkg::REG_COEF_BOTTOM, draw_coef_row($urandom_range(0, 3) == 0));
			if ($urandom_range(0, 9) == 0)
				cfg_write(3'($urandom_range(CFG_IDX_SPARE_LO, CFG_IDX_SPARE_HI)), rand_word());
			if ($urandom_range(0, 5) == 0) begin
				cut = $urandom_range(1, used_width() * used_height() - 1);
				repeat (cut) send_pixel(draw_pixel(extremes));
				drain();
				if ($urandom_range(0, 1))
					cfg_write(c3cf_pkg::REG_IMAGE_WIDTH, draw_width_data());
				if ($urandom_range(0, 1))
					cfg_write(c3cf_pkg::REG_IMAGE_HEIGHT, draw_height_data());
			end
			finish_frame(extremes);
		end
	endtask

	// ------------------------------------------------------------------
	// Sink side: hold off out_ready for a drawn number of cycles per result.
	// ------------------------------------------------------------------
	initial begin
		int gap;
		forever begin
			gap = draw_gap(out_idle);
			repeat (gap) begin
				@(negedge clk);
				out_ready <= 1'b0;
			end
			@(negedge clk);
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Compare every result beat against the oldest queued expectation.
	always @(posedge clk) begin
		filt_result_t exp_res;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				$error("unexpected result: pixel_out %0d at row %0d col %0d",
					pixel_out, out_row, out_col);
				mismatches++;
			end else begin
				exp_res = expected_results.pop_front();
				if (pixel_out !== exp_res.pix) begin
					$error("pixel_out: expected %0d, got %0d", exp_res.pix, pixel_out);
					mismatches++;
				end
				if (out_row !== exp_res.row) begin
					$error("out_row: expected %0d, got %0d", exp_res.row, out_row);
					mismatches++;
				end
				if (out_col !== exp_res.col) begin
					$error("out_col: expected %0d, got %0d", exp_res.col, out_col);
					mismatches++;
				end
				if (frame_last !== exp_res.last) begin
					$error("frame_last: expected %0b, got %0b", exp_res.last, frame_last);
					mismatches++;
				end
			end
		end
	end

	// Watchdog: end the run if no beat moves on any channel for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_conv3x3_clamp_filter: done, errors");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		pixel_in     = '0;
		out_ready    = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = c3cf_pkg::REG_IMAGE_WIDTH;
		cfg_data     = '0;
		in_idle      = IDLE_NONE;
		out_idle     = IDLE_NONE;
		mismatches   = 0;
		pixels_sent  = 0;
		results_seen = 0;
		cfg_writes   = 0;
		frames_done  = 0;
		quiet_cycles = 0;
		// Model reset: register defaults, empty window, position at the corner.
		img_width_reg  = c3cf_pkg::WIDTH_RST;
		img_height_reg = c3cf_pkg::HEIGHT_RST;
		coef_rows[0]   = c3cf_pkg::COEF_TOP_RST;
		coef_rows[1]   = c3cf_pkg::COEF_MID_RST;
		coef_rows[2]   = c3cf_pkg::COEF_BOT_RST;
		next_col       = 0;
		next_row       = 0;
		for (int i = 0; i < c3cf_pkg::MAX_WIDTH_DEF; i++) begin
			line_older[i] = '0;
			line_newer[i] = '0;
		end
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				win_px[i][j] = '0;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_directed_extremes();
		test_width_extremes();
		test_height_extremes();
		test_midframe_geometry();
		test_random_frames();
		drain();

		$display("Sent %0d pixels in %0d frames, checked %0d filtered results, %0d register writes.",
			pixels_sent, frames_done, results_seen, cfg_writes);
		$display("Geometry ran from the clamped minimum to the widest row, with mid-frame changes.");
		if (mismatches == 0)
			$display("tb_conv3x3_clamp_filter: done, clean");
		else
			$display("tb_conv3x3_clamp_filter: done, errors");
		$finish;
	end

endmodule

[conv3x3_clamp_filter.f]
rtl/c3cf_pkg.sv
rtl/c3cf_line_buf.sv
rtl/c3cf_kernel.sv
rtl/conv3x3_clamp_filter.sv
verif/tb_conv3x3_clamp_filter.sv
